@@ rtl/septic_trajectory_generator_assert.svh @@
// Assertion macros for the septic trajectory generator.
// Used by septic_trajectory_generator.sv; expects i_clk and i_rst_n in scope.
`ifndef SEPTIC_TRAJECTORY_GENERATOR_ASSERT_SVH
`define SEPTIC_TRAJECTORY_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define STG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define STG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define STG_ASSERT_IMP(lbl, ante, cons, msg)
`define STG_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/stg_pkg.sv @@
// Package for the septic trajectory generator: sequencer states, shape codes,
// fixed-point widths, shape polynomial coefficients and output saturation.
package stg_pkg;

    localparam int ACC_W      = 80;   // serial multiplier accumulator
    localparam int MB_W       = 33;   // serial multiplier operand
    localparam int DIV_W      = 64;   // divider dividend / quotient
    localparam int DIV_CNT_W  = 6;
    localparam int SHAPE_BITS = 24;   // shapes and tau are Q24
    localparam int P_W        = 40;   // signed Horner value
    localparam int X_W        = 48;   // scaled magnitude
    localparam int CAP_W      = 41;   // magnitudes clamp at 2^40
    localparam int SAT_W      = 50;   // signed value before saturation

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INV_DIV,
        ST_INV_END,
        ST_TAU_MUL,
        ST_SHAPE_INIT,
        ST_QMUL,
        ST_QPOST,
        ST_MAG_MUL,
        ST_RATE_MUL,
        ST_RATE_DIV,
        ST_RATE_POST,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        SH_POS,
        SH_VEL,
        SH_ACC
    } t_shape;

    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    // Coefficient of tau^k in the reduced shape polynomial (k = 0..3).
    function automatic logic signed [12:0] shape_coef(t_shape sh, logic [1:0] k);
        logic signed [12:0] c;
        c = '0;
        unique case (sh)
            SH_POS: begin
                unique case (k)
                    2'd0: c = 13'sd35;
                    2'd1: c = -13'sd84;
                    2'd2: c = 13'sd70;
                    default: c = -13'sd20;
                endcase
            end
            SH_VEL: begin
                unique case (k)
                    2'd0: c = 13'sd140;
                    2'd1: c = -13'sd420;
                    2'd2: c = 13'sd420;
                    default: c = -13'sd140;
                endcase
            end
            default: begin
                unique case (k)
                    2'd0: c = 13'sd420;
                    2'd1: c = -13'sd1680;
                    2'd2: c = 13'sd2100;
                    default: c = -13'sd840;
                endcase
            end
        endcase
        return c;
    endfunction

    // Number of rounded multiplications by tau: three Horner steps plus the
    // trailing power of tau.
    function automatic logic [2:0] shape_steps(t_shape sh);
        logic [2:0] s;
        unique case (sh)
            SH_POS:  s = 3'd7;
            SH_VEL:  s = 3'd6;
            default: s = 3'd5;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] sat32(logic signed [SAT_W-1:0] v);
        logic [31:0] r;
        if ((&v[SAT_W-1:31]) || !(|v[SAT_W-1:31])) begin
            r = v[31:0];
        end else if (v[SAT_W-1]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

@@ rtl/septic_trajectory_generator.sv @@
// One axis of a rest-to-rest seventh-order trajectory generator.
// Depends on stg_pkg and the assertion macros in septic_trajectory_generator_assert.svh.
//
// Usage: the input channel (i_in_valid / o_in_stall) carries one word per
// item. A start word (operation 0) loads a target and a run length N; it is
// dropped when a run is active or N is zero. Each tick word (operation 1)
// yields one result word on the output channel (o_out_valid / i_out_stall):
// position, velocity and acceleration in Q16.16, and a flag on the last sample
// of the run. A tick with no active run returns the rest position.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes the rest
// position; it is taken only while the sequencer is idle and ignored during a run.
// Datapath: all arithmetic runs through one bit-serial shift-add multiplier and
// one restoring divider that retires one quotient bit per cycle. A start word
// runs the 64-step division for 1/N. A running tick performs 18
// multiplications by tau, three multiplications by the span and three
// 64-step rate divisions. An idle tick skips the arithmetic.
// One item at a time.
// A finished result waits in the output register while the next word is
// accepted; the sequencer holds in its output step only while that register
// is full and stalled. Reset (synchronous, active low) empties the block and
// sets the rest position to zero.
`include "septic_trajectory_generator_assert.svh"

module septic_trajectory_generator #(
    parameter int SAMPLE_RATE_HZ = 100,
    parameter int COUNT_WIDTH    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_initial_position,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [31:0] i_target_position,
    input  logic [15:0] i_duration_samples,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_position,
    output logic [31:0] o_velocity,
    output logic [31:0] o_acceleration,
    output logic        o_last_sample
);
    import stg_pkg::*;

    localparam int CW = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;
    localparam logic [CAP_W-1:0] MAG_CAP = CAP_W'(1) << (CAP_W - 1);
    localparam logic [ACC_W-1:0] Q_HALF  = ACC_W'(1) << (SHAPE_BITS - 1);

    t_state r_state, n_state;

    // Run state.
    logic          r_running;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_len;
    logic [31:0]   r_start;
    logic [31:0]   r_end;
    logic [31:0]   r_inv;

    // Sequencer counters.
    t_shape               r_shape;
    logic [2:0]           r_hk;
    logic                 r_pass;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_out_valid;

    // Serial datapath.
    logic [ACC_W-1:0]       r_ma;
    logic [MB_W-1:0]        r_mb;
    logic [ACC_W-1:0]       r_acc;
    logic [DIV_W-1:0]       r_dq;
    logic [CW-1:0]          r_rem;
    logic signed [P_W-1:0]  r_p;
    logic [SHAPE_BITS:0]    r_t;
    logic [32:0]            r_dm;
    logic                   r_dneg;
    logic                   r_sneg;
    logic [31:0]            r_pos_res;
    logic [31:0]            r_vel_res;
    logic [31:0]            r_acc_res;
    logic [31:0]            r_o_pos;
    logic [31:0]            r_o_vel;
    logic [31:0]            r_o_acc;
    logic                   r_o_last;

    logic                   in_acc;
    logic                   cfg_wr;
    logic [CW-1:0]          n_in;
    logic                   mul_done;
    logic                   div_last;
    logic                   out_free;
    logic                   last_smp;
    logic [CW:0]            rem_sh;
    logic                   div_ge;
    logic [CW-1:0]          rem_nx;
    logic [SHAPE_BITS:0]    tau_nx;
    logic signed [32:0]     delta;
    logic [ACC_W-1:0]       q_round;
    logic signed [P_W-1:0]  m_q;
    logic signed [P_W-1:0]  p_q;
    logic signed [P_W-1:0]  c_ext;
    logic signed [P_W-1:0]  p_new;
    logic [P_W-1:0]         p_new_mag;
    logic signed [P_W-1:0]  c_init;
    logic [P_W-1:0]         c_init_mag;
    logic                   hk_last;
    logic [X_W-1:0]         m_mag;
    logic signed [SAT_W-1:0] pos_sum;
    logic [CAP_W-1:0]       rate_res;
    logic signed [SAT_W-1:0] rate_val;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign cfg_wr   = i_cfg_valid && o_cfg_ready;
    assign n_in     = i_duration_samples[CW-1:0];
    assign mul_done = (r_mb == '0);
    assign div_last = (r_cnt == DIV_CNT_W'(DIV_W - 1));
    assign out_free = !r_out_valid || !i_out_stall;
    assign last_smp = r_running && (({1'b0, r_idx} + (CW+1)'(1)) >= {1'b0, r_len});

    // One restoring division step.
    assign rem_sh = {r_rem, r_dq[DIV_W-1]};
    assign div_ge = (rem_sh >= {1'b0, r_len});
    assign rem_nx = div_ge ? CW'(rem_sh - {1'b0, r_len}) : rem_sh[CW-1:0];

    assign tau_nx = (r_acc[ACC_W-1:8] > (ACC_W-8)'(1 << SHAPE_BITS))
                    ? (SHAPE_BITS+1)'(1 << SHAPE_BITS) : r_acc[8 +: SHAPE_BITS+1];
    assign delta  = $signed({r_end[31], r_end}) - $signed({r_start[31], r_start});

    // Rounded product by tau, sign restored, then the next Horner coefficient.
    assign q_round   = r_acc + Q_HALF;
    assign m_q       = $signed(q_round[SHAPE_BITS +: P_W]);
    assign p_q       = r_p[P_W-1] ? -m_q : m_q;
    assign c_ext     = P_W'(shape_coef(r_shape, 2'(3'd2 - r_hk)));
    assign p_new     = (r_hk < 3'd3) ? p_q + (c_ext <<< SHAPE_BITS) : p_q;
    assign p_new_mag = p_new[P_W-1] ? P_W'(-p_new) : P_W'(p_new);
    assign hk_last   = (3'(r_hk + 3'd1) == shape_steps(r_shape));
    assign c_init    = P_W'(shape_coef(r_shape, 2'd3)) <<< SHAPE_BITS;
    assign c_init_mag = c_init[P_W-1] ? P_W'(-c_init) : P_W'(c_init);

    assign m_mag   = q_round[SHAPE_BITS +: X_W];
    assign pos_sum = SAT_W'($signed(r_start))
                     + ((r_dneg ^ r_sneg) ? -$signed(SAT_W'(m_mag)) : $signed(SAT_W'(m_mag)));

    assign rate_res = (r_dq > DIV_W'(MAG_CAP)) ? MAG_CAP : r_dq[CAP_W-1:0];
    assign rate_val = (r_dneg ^ r_sneg) ? -$signed(SAT_W'(rate_res)) : $signed(SAT_W'(rate_res));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (t_op'(i_operation) == OP_START) begin
                        if (!r_running && (n_in != '0)) begin
                            n_state = ST_INV_DIV;
                        end
                    end else if (r_running) begin
                        n_state = ST_TAU_MUL;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_INV_DIV:    if (div_last) n_state = ST_INV_END;
            ST_INV_END:    n_state = ST_IDLE;
            ST_TAU_MUL:    if (mul_done) n_state = ST_SHAPE_INIT;
            ST_SHAPE_INIT: n_state = ST_QMUL;
            ST_QMUL:       if (mul_done) n_state = ST_QPOST;
            ST_QPOST:      n_state = hk_last ? ST_MAG_MUL : ST_QMUL;
            ST_MAG_MUL: begin
                if (mul_done) begin
                    n_state = (r_shape == SH_POS) ? ST_SHAPE_INIT : ST_RATE_MUL;
                end
            end
            ST_RATE_MUL:   if (mul_done) n_state = ST_RATE_DIV;
            ST_RATE_DIV:   if (div_last) n_state = ST_RATE_POST;
            ST_RATE_POST: begin
                if (r_pass) begin
                    n_state = ST_RATE_MUL;
                end else if (r_shape == SH_VEL) begin
                    n_state = ST_SHAPE_INIT;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT:        if (out_free) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_cfg_ready = (r_state == ST_IDLE);
    end

    // Control and run state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_running   <= 1'b0;
            r_idx       <= '0;
            r_len       <= '0;
            r_start     <= '0;
            r_end       <= '0;
            r_inv       <= '0;
            r_shape     <= SH_POS;
            r_hk        <= '0;
            r_pass      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr && !r_running) begin
                r_start <= i_cfg_initial_position;
            end
            if ((r_state == ST_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && (t_op'(i_operation) == OP_START)
                        && !r_running && (n_in != '0)) begin
                        r_len     <= n_in;
                        r_end     <= i_target_position;
                        r_idx     <= '0;
                        r_running <= 1'b1;
                        r_cnt     <= '0;
                    end
                end
                ST_INV_DIV: r_cnt <= r_cnt + DIV_CNT_W'(1);
                ST_INV_END: begin
                    // With N = 1 the reciprocal 2^32 does not fit; it clamps.
                    r_inv <= (r_len == CW'(1)) ? 32'hFFFF_FFFF : r_dq[31:0];
                end
                ST_TAU_MUL: if (mul_done) r_shape <= SH_POS;
                ST_SHAPE_INIT: r_hk <= '0;
                ST_QPOST: r_hk <= 3'(r_hk + 3'd1);
                ST_MAG_MUL: begin
                    if (mul_done) begin
                        if (r_shape == SH_POS) begin
                            r_shape <= SH_VEL;
                        end else begin
                            r_pass <= (r_shape == SH_ACC);
                        end
                    end
                end
                ST_RATE_MUL: if (mul_done) r_cnt <= '0;
                ST_RATE_DIV: r_cnt <= r_cnt + DIV_CNT_W'(1);
                ST_RATE_POST: begin
                    if (r_pass) begin
                        r_pass <= 1'b0;
                    end else if (r_shape == SH_VEL) begin
                        r_shape <= SH_ACC;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        if (r_running) begin
                            if (last_smp) begin
                                r_start   <= r_end;
                                r_idx     <= '0;
                                r_running <= 1'b0;
                            end else begin
                                r_idx <= r_idx + CW'(1);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Serial datapath and result words.
    always_ff @(posedge i_clk) begin
        unique case (r_state) inside
            ST_IDLE: begin
                if (in_acc) begin
                    r_dq  <= DIV_W'(1) << 32;
                    r_rem <= '0;
                    r_ma  <= ACC_W'(r_inv);
                    r_mb  <= MB_W'(r_idx);
                    r_acc <= '0;
                    r_pos_res <= r_start;
                    r_vel_res <= '0;
                    r_acc_res <= '0;
                end
            end
            ST_INV_DIV, ST_RATE_DIV: begin
                r_rem <= rem_nx;
                r_dq  <= {r_dq[DIV_W-2:0], div_ge};
            end
            ST_TAU_MUL, ST_QMUL, ST_MAG_MUL, ST_RATE_MUL: begin
                if (!mul_done) begin
                    if (r_mb[0]) begin
                        r_acc <= r_acc + r_ma;
                    end
                    r_ma <= {r_ma[ACC_W-2:0], 1'b0};
                    r_mb <= {1'b0, r_mb[MB_W-1:1]};
                end else if (r_state == ST_TAU_MUL) begin
                    r_t    <= tau_nx;
                    r_dneg <= delta[32];
                    r_dm   <= delta[32] ? 33'(-delta) : 33'(delta);
                end else if (r_state == ST_MAG_MUL) begin
                    if (r_shape == SH_POS) begin
                        r_pos_res <= sat32(pos_sum);
                    end else begin
                        r_ma  <= ACC_W'(m_mag);
                        r_mb  <= MB_W'(SAMPLE_RATE_HZ);
                        r_acc <= '0;
                    end
                end else if (r_state == ST_RATE_MUL) begin
                    // Rounded x * rate / N in one division.
                    r_dq  <= r_acc[DIV_W-1:0] + DIV_W'(r_len >> 1);
                    r_rem <= '0;
                end
            end
            ST_SHAPE_INIT: begin
                r_p   <= c_init;
                r_ma  <= ACC_W'(c_init_mag);
                r_mb  <= MB_W'(r_t);
                r_acc <= '0;
            end
            ST_QPOST: begin
                r_p   <= p_new;
                r_ma  <= ACC_W'(p_new_mag);
                r_mb  <= hk_last ? r_dm : MB_W'(r_t);
                r_acc <= '0;
                if (hk_last) begin
                    r_sneg <= p_new[P_W-1];
                end
            end
            ST_RATE_POST: begin
                if (r_pass) begin
                    r_ma  <= ACC_W'(rate_res);
                    r_mb  <= MB_W'(SAMPLE_RATE_HZ);
                    r_acc <= '0;
                end else if (r_shape == SH_VEL) begin
                    r_vel_res <= sat32(rate_val);
                end else begin
                    r_acc_res <= sat32(rate_val);
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    r_o_pos  <= r_pos_res;
                    r_o_vel  <= r_vel_res;
                    r_o_acc  <= r_acc_res;
                    r_o_last <= last_smp;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_position     = r_o_pos;
    assign o_velocity     = r_o_vel;
    assign o_acceleration = r_o_acc;
    assign o_last_sample  = r_o_last;

    `STG_ASSERT_IMP(a_idle_index, !r_running, r_idx == '0, "step index set outside a run")
    `STG_ASSERT_IMP(a_index_range, r_running, r_idx < r_len, "step index beyond run length")
    `STG_ASSERT_IMP(a_rem_range, r_state == ST_RATE_DIV, r_rem < r_len, "divider remainder too big")
    `STG_ASSERT_NXT(a_last_ends, (r_state == ST_OUT) && out_free && last_smp, !r_running,
                    "run still active after last sample")

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for septic_trajectory_generator, one trajectory axis.
// It needs stg_pkg and the RTL. A built-in predictor computes the expected
// position, velocity and acceleration words; typed directed rows give their own.
`timescale 1ns / 100ps

module testbench;
    import stg_pkg::*;

    localparam int RATE_HZ = 100;
    localparam longint unsigned Q_HALF = 64'd1 << 23;
    localparam longint unsigned Q_ONE = 64'd1 << 24;
    localparam longint unsigned MAG_LIMIT = 64'd1 << 40;
    localparam longint CYCLE_LIMIT = 20_000_000;
    localparam int ITEMS_PER_PHASE = 500;

    typedef struct packed {
        logic [31:0] pos;
        logic [31:0] vel;
        logic [31:0] acc;
        logic        last;
    } t_traj_word;

    typedef struct {
        t_op         op;
        logic [31:0] tgt;
        logic [15:0] dur;
        bit          typed;
        t_traj_word  res;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_initial_position = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_operation = 1'b0;
    logic [31:0] i_target_position = '0;
    logic [15:0] i_duration_samples = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_position;
    logic [31:0] o_velocity;
    logic [31:0] o_acceleration;
    logic        o_last_sample;

    septic_trajectory_generator i_dut (.*);

    // Predictor state.
    longint          rest_pos;
    longint          run_start;
    longint          run_end;
    longint unsigned run_idx;
    longint unsigned run_len;
    longint unsigned run_inv;
    bit              run_active;

    t_traj_word expected_words[$];
    int         fail_count = 0;
    longint     cycle_count = 0;
    int         send_gap_pct = 0;
    int         recv_stall_pct = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic longint unsigned mag64(longint a);
        return a < 0 ? 64'd0 - longint'(a) : longint'(a);
    endfunction

    function automatic longint round_mul(longint a, longint unsigned t);
        longint unsigned m;
        m = (mag64(a) * t + Q_HALF) >> 24;
        return a < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint eval_shape(t_shape sh, longint unsigned t);
        longint c[4];
        longint p;
        int tail;
        case (sh)
            SH_POS: begin c = '{35, -84, 70, -20}; tail = 4; end
            SH_VEL: begin c = '{140, -420, 420, -140}; tail = 3; end
            default: begin c = '{420, -1680, 2100, -840}; tail = 2; end
        endcase
        p = c[3] * longint'(Q_ONE);
        for (int k = 2; k >= 0; k--) p = round_mul(p, t) + c[k] * longint'(Q_ONE);
        for (int k = 0; k < tail; k++) p = round_mul(p, t);
        return p;
    endfunction

    function automatic longint unsigned rate_scale(longint unsigned x, longint unsigned n);
        longint unsigned q, r, res;
        q = x / n;
        r = x % n;
        if (q > MAG_LIMIT) return MAG_LIMIT;
        res = q * RATE_HZ + (r * RATE_HZ + n / 2) / n;
        return res > MAG_LIMIT ? MAG_LIMIT : res;
    endfunction

    function automatic logic [31:0] clamp32(bit neg, longint unsigned m);
        if (neg) return m > 64'h8000_0000 ? 32'h8000_0000 : 32'(-longint'(m));
        return m > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : 32'(m);
    endfunction

    // Advances the predictor by one accepted word; returns 1 when it yields a result.
    function automatic bit predict_sample(t_op op, logic [31:0] tgt, logic [15:0] dur,
                                          output t_traj_word w);
        longint unsigned n, tau, m, dmag;
        longint delta, s, p;
        w = '0;
        if (op == OP_START) begin
            n = dur;
            if (run_active || n == 0) return 0;
            run_end = longint'(signed'(tgt));
            run_len = n;
            run_idx = 0;
            run_inv = n == 1 ? 64'hFFFF_FFFF : (64'd1 << 32) / n;
            run_active = 1;
            return 0;
        end
        if (!run_active) begin
            w.pos = clamp32(run_start < 0, mag64(run_start));
            return 1;
        end
        n = run_len;
        tau = (run_idx * run_inv) >> 8;
        if (tau > Q_ONE) tau = Q_ONE;
        delta = run_end - run_start;
        dmag = mag64(delta);
        s = eval_shape(SH_POS, tau);
        p = run_start + round_mul(s, dmag) * (delta < 0 ? -1 : 1);
        w.pos = clamp32(p < 0, mag64(p));
        s = eval_shape(SH_VEL, tau);
        m = (dmag * mag64(s) + Q_HALF) >> 24;
        w.vel = clamp32((delta < 0) != (s < 0), rate_scale(m, n));
        s = eval_shape(SH_ACC, tau);
        m = (dmag * mag64(s) + Q_HALF) >> 24;
        w.acc = clamp32((delta < 0) != (s < 0), rate_scale(rate_scale(m, n), n));
        w.last = run_idx + 1 >= n;
        if (w.last) begin
            run_start = run_end;
            run_idx = 0;
            run_active = 0;
        end else begin
            run_idx = run_idx + 1;
        end
        return 1;
    endfunction

    // Result checker: the oldest expected word is compared field by field.
    always @(posedge i_clk) begin
        t_traj_word w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result word, position %h", o_position);
                fail_count++;
            end else begin
                w = expected_words.pop_front();
                if (o_position !== w.pos) begin
                    $error("position: expected %h, got %h", w.pos, o_position);
                    fail_count++;
                end
                if (o_velocity !== w.vel) begin
                    $error("velocity: expected %h, got %h", w.vel, o_velocity);
                    fail_count++;
                end
                if (o_acceleration !== w.acc) begin
                    $error("acceleration: expected %h, got %h", w.acc, o_acceleration);
                    fail_count++;
                end
                if (o_last_sample !== w.last) begin
                    $error("last_sample: expected %b, got %b", w.last, o_last_sample);
                    fail_count++;
                end
            end
        end
        if (i_rst_n) i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_word(t_op op, logic [31:0] tgt, logic [15:0] dur,
                             bit typed, t_traj_word typed_res);
        t_traj_word w;
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_target_position <= tgt;
        i_duration_samples <= dur;
        do @(posedge i_clk); while (o_in_stall);
        if (predict_sample(op, tgt, dur, w)) expected_words.push_back(typed ? typed_res : w);
    endtask

    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        // A trailing start word may still be computing 1/N.
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_rest_position(logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_initial_position <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        rest_pos = longint'(signed'(value));
        if (!run_active) run_start = rest_pos;
    endtask

    function automatic logic [31:0] random_target();
        case ($urandom_range(9)) inside
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
            default: return $urandom();
        endcase
    endfunction

    t_stim_row directed[] = '{
        '{OP_TICK, 32'h0, 16'h0, 1, '{32'h0, 32'h0, 32'h0, 1'b0}},
        '{OP_START, 32'h1234_5678, 16'h0, 1, '0},
        '{OP_TICK, 32'hFFFF_FFFF, 16'hFFFF, 1, '{32'h0, 32'h0, 32'h0, 1'b0}},
        '{OP_START, 32'h7FFF_FFFF, 16'h1, 1, '0},
        '{OP_START, 32'h0, 16'hFFFF, 1, '0},
        '{OP_TICK, 32'h0, 16'h0, 1, '{32'h0, 32'h0, 32'h0, 1'b1}},
        '{OP_TICK, 32'h0, 16'h0, 1, '{32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0}},
        '{OP_START, 32'h8000_0000, 16'h2, 0, '0},
        '{OP_TICK, 32'h0, 16'h0, 0, '0},
        '{OP_TICK, 32'h0, 16'h0, 0, '0},
        '{OP_TICK, 32'h0, 16'h0, 1, '{32'h8000_0000, 32'h0, 32'h0, 1'b0}},
        '{OP_START, 32'h0001_0000, 16'h5, 0, '0},
        '{OP_TICK, 32'h0, 16'h0, 0, '0},
        '{OP_TICK, 32'h0, 16'h0, 0, '0},
        '{OP_START, 32'h5555_AAAA, 16'hAAAA, 0, '0},
        '{OP_TICK, 32'h0, 16'h0, 0, '0},
        '{OP_TICK, 32'h0, 16'h0, 0, '0},
        '{OP_TICK, 32'h0, 16'h0, 0, '0},
        '{OP_START, 32'hFFFF_0000, 16'h3, 0, '0},
        '{OP_TICK, 32'h0, 16'h0, 0, '0},
        '{OP_TICK, 32'h0, 16'h0, 0, '0},
        '{OP_TICK, 32'h0, 16'h0, 0, '0}
    };

    initial begin
        int items;
        int n;
        logic [31:0] rest_values[3];
        rest_pos = 0;
        run_start = 0;
        run_end = 0;
        run_idx = 0;
        run_len = 0;
        run_inv = 0;
        run_active = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k])
            send_word(directed[k].op, directed[k].tgt, directed[k].dur,
                      directed[k].typed, directed[k].res);
        drain_and_settle();

        rest_values = '{32'h8000_0000, 32'h7FFF_FFFF, $urandom()};
        for (int phase = 0; phase < 3; phase++) begin
            send_gap_pct = phase == 0 ? 9 : (phase == 1 ? 49 : 0);
            recv_stall_pct = phase == 0 ? 49 : (phase == 1 ? 9 : 0);
            write_rest_position(rest_values[phase]);
            if (phase == 1) begin
                // A rest position written in mid-run must not move the active start.
                send_word(OP_START, random_target(), 16'h2, 0, '0);
                send_word(OP_TICK, 32'h0, 16'h0, 0, '0);
                drain_and_settle();
                write_rest_position($urandom());
            end
            items = 0;
            while (items < ITEMS_PER_PHASE) begin
                case ($urandom_range(19))
                    0: begin
                        send_word(OP_TICK, $urandom(), 16'($urandom()), 0, '0);
                        items++;
                    end
                    1: send_word(OP_START, $urandom(), 16'h0, 0, '0);
                    default: begin
                        n = $urandom_range(9) == 0 ? $urandom_range(40, 7) : $urandom_range(6, 1);
                        send_word(OP_START, random_target(), 16'(n), 0, '0);
                        items++;
                        for (int k = 0; k < n; k++) begin
                            // Starts during a run are dropped by the block.
                            if ($urandom_range(7) == 0)
                                send_word(OP_START, $urandom(), 16'($urandom()), 0, '0);
                            send_word(OP_TICK, $urandom(), 16'($urandom()), 0, '0);
                            items++;
                        end
                    end
                endcase
            end
            drain_and_settle();
        end

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
